// File: rtl/hrhp_pkg.sv
// Shared types, character codes and length constants for the request head parser.
package hrhp_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned PROD_W      = LENGTH_BITS + 4;
  localparam int unsigned BODY_LEN_W  = 32;

  localparam logic [PROD_W-1:0]      NUM_CAP_W = PROD_W'(1) << (LENGTH_BITS - 1);
  localparam logic [LENGTH_BITS-1:0] NUM_CAP   = LENGTH_BITS'(1) << (LENGTH_BITS - 1);
  localparam logic [LENGTH_BITS-1:0] NUM_MAX   = NUM_CAP - LENGTH_BITS'(1);
  localparam logic [BODY_LEN_W-1:0]  LEN_MAX   = BODY_LEN_W'(NUM_MAX);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [2:0] KIND_METHOD   = 3'd0;
  localparam logic [2:0] KIND_PATH     = 3'd1;
  localparam logic [2:0] KIND_QUERY    = 3'd2;
  localparam logic [2:0] KIND_HEAD_END = 3'd3;
  localparam logic [2:0] KIND_BODY     = 3'd4;

  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_QMARK = 8'h3f;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [3:0] KEY_LEN = 4'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } req_in_t;

  typedef struct packed {
    logic [2:0]                   item_kind;
    logic [7:0]                   out_byte;
    logic                         head_ok;
    logic signed [BODY_LEN_W-1:0] body_length;
    logic                         run_last;
  } req_out_t;

  typedef struct packed {
    logic [1:0] num;
    req_out_t   first;
    req_out_t   second;
  } push_t;

  // lower-case "content-length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h6c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/hrhp_parse.sv
// Input register, parser state and per-word result generation.
module hrhp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hrhp_pkg::req_in_t in_data_i,
  input  logic              room_i,
  output hrhp_pkg::push_t   push_o
);

  localparam int unsigned ACC_W = hrhp_pkg::LENGTH_BITS;
  localparam int unsigned REM_W = hrhp_pkg::LENGTH_BITS - 1;
  localparam int unsigned LEN_W = hrhp_pkg::BODY_LEN_W;

  localparam logic [1:0] NUM_IDLE   = 2'd0;
  localparam logic [1:0] NUM_DIGITS = 2'd1;
  localparam logic [1:0] NUM_DONE   = 2'd2;

  typedef enum logic [6:0] {
    PH_METHOD  = 7'b0000001,
    PH_PATH    = 7'b0000010,
    PH_DROP    = 7'b0000100,
    PH_SKIP    = 7'b0001000,
    PH_HEADER  = 7'b0010000,
    PH_BODY    = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_e;

  hrhp_pkg::req_in_t in_q;
  logic              in_valid_q;
  logic              fire;

  phase_e            phase_q, phase_d;
  logic              ms_q, ms_d;
  logic              query_q, query_d;
  logic              lt_q, lt_d;
  logic [3:0]        pos_q, pos_d;
  logic              brk_q, brk_d;
  logic [1:0]        np_q, np_d;
  logic              neg_q, neg_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  logic              f_lt, f_brk, f_neg;
  logic [3:0]        f_pos;
  logic [1:0]        f_np;
  logic [ACC_W-1:0]  f_acc;

  logic [7:0]                    b;
  logic [7:0]                    lc;
  logic                          ws;
  logic                          digit;
  logic [hrhp_pkg::PROD_W-1:0]   prod;
  logic [ACC_W-1:0]              acc_sat;

  logic                 step_emit, end_emit;
  hrhp_pkg::req_out_t   step_res, end_res;

  function automatic hrhp_pkg::req_out_t mk_res(input logic [2:0] kind, input logic [7:0] data,
                                                input logic ok, input logic [LEN_W-1:0] len);
    hrhp_pkg::req_out_t r;
    r.item_kind   = kind;
    r.out_byte    = data;
    r.head_ok     = ok;
    r.body_length = $signed(len);
    r.run_last    = 1'b0;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] num_value(input logic neg, input logic [ACC_W-1:0] acc);
    logic [LEN_W-1:0] v;
    if (neg) begin
      v = LEN_W'(0) - LEN_W'(acc);
    end else if (acc > hrhp_pkg::NUM_MAX) begin
      v = hrhp_pkg::LEN_MAX;
    end else begin
      v = LEN_W'(acc);
    end
    return v;
  endfunction

  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  assign b     = in_q.data_byte;
  assign lc    = (b inside {[8'h41:8'h5a]}) ? b + 8'h20 : b;
  assign ws    = (b == hrhp_pkg::CHAR_SP) || (b inside {[8'h09:8'h0d]});
  assign digit = b inside {[8'h30:8'h39]};
  assign prod  = hrhp_pkg::PROD_W'({acc_q, 3'b000}) + hrhp_pkg::PROD_W'({acc_q, 1'b0})
               + hrhp_pkg::PROD_W'(b[3:0]);
  assign acc_sat = (prod > hrhp_pkg::NUM_CAP_W) ? hrhp_pkg::NUM_CAP : prod[ACC_W-1:0];

  // header character: trim, key match, then the number
  always_comb begin
    f_lt  = lt_q;
    f_pos = pos_q;
    f_brk = brk_q;
    f_np  = np_q;
    f_neg = neg_q;
    f_acc = acc_q;
    if (lt_q || !ws) begin
      f_lt = 1'b1;
      if (!brk_q) begin
        if (pos_q != hrhp_pkg::KEY_LEN) begin
          if (lc == hrhp_pkg::key_char(pos_q)) begin
            f_pos = pos_q + 4'd1;
          end else begin
            f_brk = 1'b1;
          end
        end else if (np_q == NUM_IDLE && ws) begin
          f_np = NUM_IDLE;
        end else if (np_q == NUM_IDLE &&
                     (b == hrhp_pkg::CHAR_MINUS || b == hrhp_pkg::CHAR_PLUS)) begin
          f_np  = NUM_DIGITS;
          f_neg = (b == hrhp_pkg::CHAR_MINUS);
        end else if (np_q != NUM_DONE && digit) begin
          f_np  = NUM_DIGITS;
          f_acc = acc_sat;
        end else begin
          f_np = NUM_DONE;
        end
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    ms_d      = ms_q;
    query_d   = query_q;
    lt_d      = lt_q;
    pos_d     = pos_q;
    brk_d     = brk_q;
    np_d      = np_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    len_d     = len_q;
    rem_d     = rem_q;
    step_emit = 1'b0;
    end_emit  = 1'b0;
    step_res  = '0;
    end_res   = '0;

    case (phase_q)
      PH_PATH: begin
        if (b == hrhp_pkg::CHAR_SP) begin
          phase_d = PH_DROP;
          len_d   = '0;
        end else if (b == hrhp_pkg::CHAR_CR) begin
          step_emit = 1'b1;
          step_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, '0);
          phase_d   = PH_DISCARD;
        end else if (b == hrhp_pkg::CHAR_QMARK && !query_q) begin
          query_d = 1'b1;
        end else begin
          step_emit = 1'b1;
          step_res  = mk_res(query_q ? hrhp_pkg::KIND_QUERY : hrhp_pkg::KIND_PATH,
                             b, 1'b0, '0);
        end
      end
      PH_DROP: begin
        if (b == hrhp_pkg::CHAR_CR) begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        phase_d = PH_HEADER;
        lt_d    = 1'b0;
        pos_d   = '0;
        brk_d   = 1'b0;
        np_d    = NUM_IDLE;
        neg_d   = 1'b0;
        acc_d   = '0;
      end
      PH_HEADER: begin
        if (b == hrhp_pkg::CHAR_LF) begin
          if (!lt_q) begin
            step_emit = 1'b1;
            step_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_q);
            if (len_q != '0 && !len_q[LEN_W-1]) begin
              rem_d   = len_q[REM_W-1:0];
              phase_d = PH_BODY;
            end else begin
              phase_d = PH_METHOD;
              ms_d    = 1'b0;
              query_d = 1'b0;
            end
          end else if (pos_q == hrhp_pkg::KEY_LEN && !brk_q) begin
            len_d = num_value(neg_q, acc_q);
          end
          lt_d  = 1'b0;
          pos_d = '0;
          brk_d = 1'b0;
          np_d  = NUM_IDLE;
          neg_d = 1'b0;
          acc_d = '0;
        end else begin
          lt_d  = f_lt;
          pos_d = f_pos;
          brk_d = f_brk;
          np_d  = f_np;
          neg_d = f_neg;
          acc_d = f_acc;
        end
      end
      PH_BODY: begin
        if (rem_q == '0) begin
          phase_d = PH_METHOD;
          ms_d    = 1'b0;
          query_d = 1'b0;
        end else begin
          step_emit = 1'b1;
          step_res  = mk_res(hrhp_pkg::KIND_BODY, b, 1'b0, '0);
          rem_d     = rem_q - REM_W'(1);
          if (rem_q == REM_W'(1)) begin
            phase_d = PH_METHOD;
            ms_d    = 1'b0;
            query_d = 1'b0;
          end
        end
        lt_d  = (rem_q == '0 || rem_q == REM_W'(1)) ? 1'b0 : lt_q;
        pos_d = (rem_q == '0 || rem_q == REM_W'(1)) ? 4'd0 : pos_q;
        brk_d = (rem_q == '0 || rem_q == REM_W'(1)) ? 1'b0 : brk_q;
        np_d  = (rem_q == '0 || rem_q == REM_W'(1)) ? NUM_IDLE : np_q;
        neg_d = (rem_q == '0 || rem_q == REM_W'(1)) ? 1'b0 : neg_q;
        acc_d = (rem_q == '0 || rem_q == REM_W'(1)) ? '0 : acc_q;
      end
      PH_DISCARD: begin
        phase_d = PH_DISCARD;
      end
      default: begin
        phase_d = PH_METHOD;
        if (b == hrhp_pkg::CHAR_SP) begin
          if (!ms_q) begin
            step_emit = 1'b1;
            step_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, '0);
            phase_d   = PH_DISCARD;
          end else begin
            phase_d = PH_PATH;
          end
        end else if (b == hrhp_pkg::CHAR_CR) begin
          step_emit = 1'b1;
          step_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, '0);
          phase_d   = PH_DISCARD;
        end else begin
          step_emit = 1'b1;
          step_res  = mk_res(hrhp_pkg::KIND_METHOD, b, 1'b0, '0);
          ms_d      = 1'b1;
        end
      end
    endcase

    if (in_q.stream_end) begin
      if ((phase_d == PH_METHOD && ms_d) || phase_d == PH_PATH) begin
        end_emit = 1'b1;
        end_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, '0);
      end else if (phase_d == PH_DROP || phase_d == PH_SKIP) begin
        end_emit = 1'b1;
        end_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_d);
      end else if (phase_d == PH_HEADER) begin
        if (lt_d && pos_d == hrhp_pkg::KEY_LEN && !brk_d) begin
          len_d = num_value(neg_d, acc_d);
        end
        end_emit = 1'b1;
        end_res  = mk_res(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_d);
      end
      phase_d = PH_METHOD;
      ms_d    = 1'b0;
      query_d = 1'b0;
      lt_d    = 1'b0;
      pos_d   = '0;
      brk_d   = 1'b0;
      np_d    = NUM_IDLE;
      neg_d   = 1'b0;
      acc_d   = '0;
      rem_d   = '0;
    end
  end

  always_comb begin
    push_o.num             = fire ? (2'(step_emit) + 2'(end_emit)) : 2'd0;
    push_o.first           = step_emit ? step_res : end_res;
    push_o.first.run_last  = !(step_emit && end_emit);
    push_o.second          = end_res;
    push_o.second.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD;
      ms_q    <= 1'b0;
      query_q <= 1'b0;
      lt_q    <= 1'b0;
      pos_q   <= '0;
      brk_q   <= 1'b0;
      np_q    <= NUM_IDLE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      ms_q    <= ms_d;
      query_q <= query_d;
      lt_q    <= lt_d;
      pos_q   <= pos_d;
      brk_q   <= brk_d;
      np_q    <= np_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// File: rtl/hrhp_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one.
module hrhp_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hrhp_pkg::push_t    push_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hrhp_pkg::req_out_t out_data_o
);

  hrhp_pkg::req_out_t                  mem_q [hrhp_pkg::FIFO_DEPTH];
  logic [hrhp_pkg::FIFO_PTR_W-1:0]     wr_q, rd_q;
  logic [hrhp_pkg::FIFO_CNT_W-1:0]     cnt_q;
  logic                                pop;

  assign room_o      = cnt_q <= hrhp_pkg::FIFO_CNT_W'(hrhp_pkg::FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + hrhp_pkg::FIFO_PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + hrhp_pkg::FIFO_PTR_W'(push_i.num);
      rd_q  <= rd_q + hrhp_pkg::FIFO_PTR_W'(pop);
      cnt_q <= cnt_q + hrhp_pkg::FIFO_CNT_W'(push_i.num) - hrhp_pkg::FIFO_CNT_W'(pop);
    end
  end

endmodule

// File: rtl/http_request_head_parser.sv
// Top level of the request head parser: input register, parser, result queue.
// The first result of a word is offered once the word has passed the input register and been written into the queue.
// Throughput: one word per cycle while each word gives at most one result and the queue has
// room; a word that gives two results (stream end) puts both in the queue, which offers them in turn.
// Reset: asynchronous, active low; parser returns to awaiting method, queue empties.
module http_request_head_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hrhp_pkg::req_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hrhp_pkg::req_out_t out_data_o
);

  hrhp_pkg::push_t push;
  logic            room;

  hrhp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  hrhp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/hrhp_checker.sv
// Port-level checks on the request head parser, bound to its top level.
module hrhp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hrhp_pkg::req_out_t out_data_o
);

  logic head_end;

  assign head_end = out_valid_o && out_data_o.item_kind == hrhp_pkg::KIND_HEAD_END;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_head_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_end |-> out_data_o.run_last && out_data_o.out_byte == 8'h00)
    else $error("head end not last or carries a byte");

  a_other_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !head_end |-> !out_data_o.head_ok && out_data_o.body_length == 0)
    else $error("byte result carries head fields");

  a_fail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_end && !out_data_o.head_ok |-> out_data_o.body_length == 0)
    else $error("failed head carries a length");

endmodule

bind http_request_head_parser hrhp_checker u_checker (.*);

// File: tb/tb.sv
// Testbench for the request head parser: directed and random byte streams, scored per result.
`timescale 1ns / 100ps

module tb;

  typedef enum logic [6:0] {
    ST_METHOD    = 7'b0000001,
    ST_TARGET    = 7'b0000010,
    ST_LINE_REST = 7'b0000100,
    ST_SKIP_LF   = 7'b0001000,
    ST_HEADERS   = 7'b0010000,
    ST_BODY      = 7'b0100000,
    ST_DISCARD   = 7'b1000000
  } parse_state_e;

  localparam logic [8*15-1:0] LEN_KEY     = "content-length:";
  localparam int              QUIET_LIMIT = 2000;
  localparam logic [7:0]      CHAR_TAB    = 8'h09;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  hrhp_pkg::req_in_t  in_word   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hrhp_pkg::req_out_t out_word;

  hrhp_pkg::req_out_t parser_items_q[$];
  hrhp_pkg::req_out_t word_items[2];
  int                 word_cnt;
  logic [7:0]         burst[$];
  int                 plan_len;
  bit                 big_body;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int words_sent     = 0;
  bit gaps_on        = 1'b1;
  bit stall_on       = 1'b1;

  parse_state_e hp_state   = ST_METHOD;
  logic         method_seen = 1'b0;
  logic         query_on    = 1'b0;
  logic         line_text   = 1'b0;
  int           key_pos     = 0;
  logic         key_miss    = 1'b0;
  logic [1:0]   num_state   = 2'd0;
  logic         num_neg     = 1'b0;
  logic [31:0]  num_acc     = '0;
  logic [31:0]  len_held    = '0;
  logic [31:0]  body_left   = '0;

  http_request_head_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= stall_on ? ($urandom_range(99) >= 35) : 1'b1;
  end

  // Parser prediction

  function automatic void emit_item(logic [2:0] kind, logic [7:0] b, logic ok, logic [31:0] len);
    hrhp_pkg::req_out_t r;
    if (word_cnt >= 2) return;
    r             = '0;
    r.item_kind   = kind;
    r.out_byte    = b;
    r.head_ok     = ok;
    r.body_length = len;
    word_items[word_cnt] = r;
    word_cnt++;
  endfunction

  function automatic void reset_line_scan();
    line_text = 1'b0;
    key_pos   = 0;
    key_miss  = 1'b0;
    num_state = 2'd0;
    num_neg   = 1'b0;
    num_acc   = '0;
  endfunction

  function automatic void begin_request();
    hp_state    = ST_METHOD;
    method_seen = 1'b0;
    query_on    = 1'b0;
    reset_line_scan();
  endfunction

  function automatic logic [31:0] length_value();
    logic [31:0] maxpos;
    maxpos = 32'((64'd1 << (hrhp_pkg::LENGTH_BITS - 1)) - 64'd1);
    if (num_neg) return 32'd0 - num_acc;
    return (num_acc > maxpos) ? maxpos : num_acc;
  endfunction

  function automatic void scan_header_char(logic [7:0] b);
    logic        ws;
    logic [7:0]  lc;
    logic [63:0] v;
    logic [63:0] cap;
    ws  = (b == hrhp_pkg::CHAR_SP) || (b >= 8'd9 && b <= 8'd13);
    cap = 64'd1 << (hrhp_pkg::LENGTH_BITS - 1);
    if (!line_text) begin
      if (ws) return;
      line_text = 1'b1;
    end
    if (key_miss) return;
    if (key_pos < int'(hrhp_pkg::KEY_LEN)) begin
      lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (lc == LEN_KEY[8*(14-key_pos) +: 8]) key_pos++;
      else key_miss = 1'b1;
      return;
    end
    if (num_state == 2'd0) begin
      if (ws) return;
      num_state = 2'd1;
      if (b == hrhp_pkg::CHAR_MINUS || b == hrhp_pkg::CHAR_PLUS) begin
        num_neg = (b == hrhp_pkg::CHAR_MINUS);
        return;
      end
    end
    if (num_state == 2'd1 && b >= "0" && b <= "9") begin
      v       = 64'(num_acc) * 64'd10 + 64'(b - 8'h30);
      num_acc = (v > cap) ? cap[31:0] : v[31:0];
    end else begin
      num_state = 2'd2;
    end
  endfunction

  function automatic void close_line();
    if (line_text && key_pos == int'(hrhp_pkg::KEY_LEN) && !key_miss) len_held = length_value();
    reset_line_scan();
  endfunction

  function automatic void close_head_ok();
    emit_item(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_held);
    if (len_held != 0 && !len_held[31]) begin
      body_left = len_held;
      hp_state  = ST_BODY;
    end else begin
      begin_request();
    end
  endfunction

  function automatic void close_head_bad();
    emit_item(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, 32'd0);
    hp_state = ST_DISCARD;
  endfunction

  function automatic void parse_word(hrhp_pkg::req_in_t w);
    logic [7:0] b;
    b        = w.data_byte;
    word_cnt = 0;
    case (hp_state)
      ST_TARGET: begin
        if (b == hrhp_pkg::CHAR_SP) begin
          hp_state = ST_LINE_REST;
          len_held = '0;
        end else if (b == hrhp_pkg::CHAR_CR) begin
          close_head_bad();
        end else if (b == hrhp_pkg::CHAR_QMARK && !query_on) begin
          query_on = 1'b1;
        end else begin
          emit_item(query_on ? hrhp_pkg::KIND_QUERY : hrhp_pkg::KIND_PATH, b, 1'b0, 32'd0);
        end
      end
      ST_LINE_REST: begin
        if (b == hrhp_pkg::CHAR_CR) hp_state = ST_SKIP_LF;
      end
      ST_SKIP_LF: begin
        hp_state = ST_HEADERS;
        reset_line_scan();
      end
      ST_HEADERS: begin
        if (b == hrhp_pkg::CHAR_LF) begin
          if (!line_text) close_head_ok();
          else close_line();
        end else begin
          scan_header_char(b);
        end
      end
      ST_BODY: begin
        if (body_left == 0) begin
          begin_request();
        end else begin
          emit_item(hrhp_pkg::KIND_BODY, b, 1'b0, 32'd0);
          body_left--;
          if (body_left == 0) begin_request();
        end
      end
      ST_DISCARD: ;
      default: begin
        hp_state = ST_METHOD;
        if (b == hrhp_pkg::CHAR_SP) begin
          if (!method_seen) close_head_bad();
          else hp_state = ST_TARGET;
        end else if (b == hrhp_pkg::CHAR_CR) begin
          close_head_bad();
        end else begin
          emit_item(hrhp_pkg::KIND_METHOD, b, 1'b0, 32'd0);
          method_seen = 1'b1;
        end
      end
    endcase
    if (w.stream_end) begin
      if ((hp_state == ST_METHOD && method_seen) || hp_state == ST_TARGET) begin
        emit_item(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b0, 32'd0);
      end else if (hp_state == ST_LINE_REST || hp_state == ST_SKIP_LF) begin
        emit_item(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_held);
      end else if (hp_state == ST_HEADERS) begin
        close_line();
        emit_item(hrhp_pkg::KIND_HEAD_END, 8'h00, 1'b1, len_held);
      end
      begin_request();
      body_left = '0;
    end
    if (word_cnt > 0) word_items[word_cnt-1].run_last = 1'b1;
    for (int i = 0; i < word_cnt; i++) parser_items_q.push_back(word_items[i]);
  endfunction

  // Result scoring

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_item(input hrhp_pkg::req_out_t got);
    hrhp_pkg::req_out_t want;
    if (parser_items_q.size() == 0) begin
      report_mismatch("item with nothing pending, kind", 32'(got.item_kind), 32'd0);
      return;
    end
    want = parser_items_q.pop_front();
    if (got.item_kind !== want.item_kind)
      report_mismatch("item_kind", 32'(got.item_kind), 32'(want.item_kind));
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
    if (got.head_ok !== want.head_ok)
      report_mismatch("head_ok", 32'(got.head_ok), 32'(want.head_ok));
    if (got.body_length !== want.body_length)
      report_mismatch("body_length", got.body_length, want.body_length);
    if (got.run_last !== want.run_last)
      report_mismatch("run_last", 32'(got.run_last), 32'(want.run_last));
  endtask

  always @(posedge clk) begin
    if (in_valid && in_ready) parse_word(in_word);
    if (out_valid && out_ready) check_item(out_word);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, stream_end: last};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_burst(input int end_at);
    for (int i = 0; i < burst.size() && (end_at < 0 || i <= end_at); i++)
      send_byte(burst[i], i == end_at);
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (parser_items_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] field_byte(bit wide);
    logic [7:0] c;
    c = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h21, 8'h7e));
    if (c == hrhp_pkg::CHAR_SP || c == hrhp_pkg::CHAR_CR) c = 8'h2f;
    return c;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  function automatic void add_length_header();
    logic [7:0] c;
    bit         keep;
    bit         big;
    int         val;
    string      txt;
    keep = ($urandom_range(0, 7) != 0);
    big  = 1'b0;
    val  = 0;
    for (int i = 0; i < 15; i++) begin
      c = LEN_KEY[8*(14-i) +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      burst.push_back(c);
    end
    if (!keep) burst[burst.size() - 1 - $urandom_range(0, 14)] = "x";
    repeat ($urandom_range(0, 2))
      burst.push_back($urandom_range(0, 1) ? hrhp_pkg::CHAR_SP : CHAR_TAB);
    case ($urandom_range(0, 9))
      5: begin
        if ($urandom_range(0, 1)) txt = "0";
        else txt = "";
      end
      6: txt = $sformatf("-%0d", $urandom_range(1, 99));
      7: begin
        big = 1'b1;
        if ($urandom_range(0, 1)) txt = "99999999999";
        else txt = "2147483647";
      end
      8: begin
        if ($urandom_range(0, 1)) txt = "-99999999999";
        else txt = "-2147483648";
      end
      9: begin
        val = $urandom_range(1, 12);
        txt = $sformatf("+%0d", val);
      end
      default: begin
        val = $urandom_range(1, 12);
        txt = $sformatf("%0d", val);
      end
    endcase
    add_text(txt);
    if ($urandom_range(0, 4) == 0) add_text(" x9");
    if (keep) begin
      plan_len = val;
      big_body = big;
    end
  endfunction

  function automatic void build_request();
    burst.delete();
    plan_len = 0;
    big_body = 1'b0;
    repeat ($urandom_range(1, 4)) burst.push_back(field_byte($urandom_range(0, 4) == 0));
    burst.push_back(hrhp_pkg::CHAR_SP);
    repeat ($urandom_range(0, 6))
      burst.push_back($urandom_range(0, 3) == 0 ? hrhp_pkg::CHAR_QMARK :
                      field_byte($urandom_range(0, 4) == 0));
    burst.push_back(hrhp_pkg::CHAR_SP);
    repeat ($urandom_range(0, 4)) burst.push_back(field_byte(1));
    burst.push_back(hrhp_pkg::CHAR_CR);
    burst.push_back($urandom_range(0, 7) == 0 ? field_byte(1) : hrhp_pkg::CHAR_LF);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0)
        burst.push_back($urandom_range(0, 1) ? hrhp_pkg::CHAR_SP : CHAR_TAB);
      if ($urandom_range(0, 2) != 0) begin
        add_length_header();
      end else begin
        burst.push_back(8'($urandom_range(8'h41, 8'h5a)));
        repeat ($urandom_range(0, 6))
          burst.push_back($urandom_range(0, 4) == 0 ? hrhp_pkg::CHAR_SP : field_byte(0));
      end
      if ($urandom_range(0, 3) == 0) burst.push_back(hrhp_pkg::CHAR_SP);
      if ($urandom_range(0, 1)) burst.push_back(hrhp_pkg::CHAR_CR);
      burst.push_back(hrhp_pkg::CHAR_LF);
    end
    if ($urandom_range(0, 3) == 0)
      burst.push_back($urandom_range(0, 1) ? hrhp_pkg::CHAR_SP : CHAR_TAB);
    if ($urandom_range(0, 1)) burst.push_back(hrhp_pkg::CHAR_CR);
    burst.push_back(hrhp_pkg::CHAR_LF);
    if (big_body) repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
    else repeat (plan_len) burst.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_noise();
    burst.delete();
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(0, 3)) burst.push_back(field_byte(1));
      if ($urandom_range(0, 1)) begin
        burst.push_back(hrhp_pkg::CHAR_SP);
        repeat ($urandom_range(0, 3)) burst.push_back(field_byte(1));
      end
      burst.push_back(hrhp_pkg::CHAR_CR);
    end
    repeat ($urandom_range(1, 8)) burst.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Tests

  task automatic test_request_line_errors();
    burst = {hrhp_pkg::CHAR_SP, 8'hff};
    send_burst(1);
    burst = {"A", hrhp_pkg::CHAR_CR, 8'h00};
    send_burst(2);
    burst = {"M", hrhp_pkg::CHAR_SP, hrhp_pkg::CHAR_CR, "A"};
    send_burst(3);
    burst = {"X"};
    send_burst(0);
    burst = {"G", hrhp_pkg::CHAR_SP, "/", hrhp_pkg::CHAR_QMARK, "x", hrhp_pkg::CHAR_QMARK,
             hrhp_pkg::CHAR_SP, hrhp_pkg::CHAR_CR, hrhp_pkg::CHAR_LF, hrhp_pkg::CHAR_LF};
    send_burst(-1);
    burst = {"B", hrhp_pkg::CHAR_SP, 8'hff, hrhp_pkg::CHAR_SP, "z"};
    send_burst(4);
  endtask

  task automatic test_random_traffic(input int upto);
    int cut;
    while (words_sent < upto) begin
      if ($urandom_range(0, 6) == 0) begin
        build_noise();
        cut = burst.size() - 1;
      end else begin
        build_request();
        cut = -1;
        if ($urandom_range(0, 5) == 0) cut = $urandom_range(0, burst.size() - 1);
        else if (big_body || $urandom_range(0, 9) == 0) cut = burst.size() - 1;
      end
      send_burst(cut);
    end
  endtask

  task automatic test_pause_until_drained();
    test_random_traffic(words_sent + 40);
    in_valid <= 1'b0;
    wait_drain();
    test_random_traffic(words_sent + 40);
  endtask

  task automatic test_full_rate(input int upto);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(upto);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_line_errors();
    test_random_traffic(700);
    test_pause_until_drained();
    test_full_rate(words_sent + 350);
    test_random_traffic(1550);
    in_valid <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hrhp_pkg.sv
rtl/hrhp_parse.sv
rtl/hrhp_out_fifo.sv
rtl/http_request_head_parser.sv
rtl/hrhp_checker.sv
tb/tb.sv
